/* design/fir_pkg.sv */
package fir_pkg;

  // table size and point range
  localparam int MAX_RULES  = 16;
  localparam int NUM_POINTS = 10;

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  // request codes
  localparam logic [2:0] REQ_CHECK     = 3'd0;
  localparam logic [2:0] REQ_CONFIGURE = 3'd1;
  localparam logic [2:0] REQ_DISABLE   = 3'd2;
  localparam logic [2:0] REQ_QUERY     = 3'd3;
  localparam logic [2:0] REQ_CLEAR     = 3'd4;

  // rule modes
  localparam logic [1:0] MODE_ONCE    = 2'd0;
  localparam logic [1:0] MODE_EVERY_N = 2'd1;
  localparam logic [1:0] MODE_ALWAYS  = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // request beat as it travels down the rule chain
  typedef struct packed {
    logic        vld;
    logic [2:0]  req;
    logic [3:0]  point;
    logic [1:0]  mode;
    logic [31:0] every_n;
    logic        ok;
    logic        matched;
    logic        appended;
    logic        fire;
    logic [31:0] cnt;
  } beat_t;

  // finished result
  typedef struct packed {
    logic        accepted;
    logic        fire;
    logic [31:0] fired_count;
  } result_t;

endpackage

/* design/fir_if.sv */
interface fir_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  point;
  logic [1:0]  mode;
  logic [31:0] every_n;

  modport source (output valid, output req_type, output point, output mode,
                  output every_n, input ready);
  modport sink (input valid, input req_type, input point, input mode,
                input every_n, output ready);
endinterface

interface fir_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        fire;
  logic [31:0] fired_count;

  modport source (output valid, output accepted, output fire, output fired_count,
                  input ready);
  modport sink (input valid, input accepted, input fire, input fired_count,
                output ready);
endinterface

/* design/fir_cell.sv */
module fir_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fir_pkg::IDX_W-1:0] idx_i,
  input  logic [fir_pkg::CNT_W-1:0] count_i,
  input  fir_pkg::beat_t            beat_i,
  output fir_pkg::beat_t            beat_o
);

  // one rule entry
  logic [3:0]     point_r,   point_nxt;
  logic [1:0]     mode_r,    mode_nxt;
  logic [31:0]    period_r,  period_nxt;
  logic [31:0]    seen_r,    seen_nxt;
  logic [31:0]    phase_r,   phase_nxt;
  logic [31:0]    fired_r,   fired_nxt;
  logic           enabled_r, enabled_nxt;
  fir_pkg::beat_t beat_r,    beat_nxt;

  logic        in_use;
  logic        is_free;
  logic        hit;
  logic        claim;
  logic        fire_now;
  logic [31:0] seen_inc;
  logic [31:0] phase_inc;
  logic [31:0] phase_step;

  assign in_use  = fir_pkg::CNT_W'(idx_i) < count_i;
  assign is_free = fir_pkg::CNT_W'(idx_i) == count_i;
  assign hit     = beat_i.vld && !beat_i.matched && in_use && (point_r == beat_i.point);
  assign claim   = beat_i.vld && (beat_i.req == fir_pkg::REQ_CONFIGURE) && beat_i.ok &&
                   !beat_i.matched && is_free;

  // phase tracks seen mod period; a wrap of seen lands on zero
  assign seen_inc   = seen_r + 32'd1;
  assign phase_inc  = phase_r + 32'd1;
  assign phase_step = ((seen_inc == 32'd0) || (phase_inc == period_r)) ? 32'd0 : phase_inc;

  // fire decision for a check on an enabled rule
  always_comb begin
    unique case (mode_r)
      fir_pkg::MODE_ONCE:    fire_now = (fired_r == 32'd0);
      fir_pkg::MODE_EVERY_N: fire_now = (phase_step == 32'd0);
      fir_pkg::MODE_ALWAYS:  fire_now = 1'b1;
      default:               fire_now = 1'b0;
    endcase
  end

  // rule update and beat hand-off
  always_comb begin
    beat_nxt    = beat_i;
    point_nxt   = point_r;
    mode_nxt    = mode_r;
    period_nxt  = period_r;
    seen_nxt    = seen_r;
    phase_nxt   = phase_r;
    fired_nxt   = fired_r;
    enabled_nxt = enabled_r;
    if (hit) begin
      beat_nxt.matched = 1'b1;
      unique case (beat_i.req)
        fir_pkg::REQ_CHECK: begin
          if (enabled_r) begin
            seen_nxt  = seen_inc;
            phase_nxt = phase_step;
            if (fire_now) begin
              fired_nxt = fired_r + 32'd1;
            end
            beat_nxt.fire = fire_now;
          end
          beat_nxt.cnt = fired_nxt;
        end
        fir_pkg::REQ_CONFIGURE: begin
          if (beat_i.ok) begin
            point_nxt    = beat_i.point;
            mode_nxt     = beat_i.mode;
            period_nxt   = (beat_i.mode == fir_pkg::MODE_EVERY_N) ? beat_i.every_n : 32'd0;
            seen_nxt     = 32'd0;
            phase_nxt    = 32'd0;
            fired_nxt    = 32'd0;
            enabled_nxt  = 1'b1;
            beat_nxt.cnt = 32'd0;
          end else begin
            beat_nxt.cnt = fired_r;
          end
        end
        fir_pkg::REQ_DISABLE: begin
          enabled_nxt  = 1'b0;
          beat_nxt.cnt = fired_r;
        end
        fir_pkg::REQ_QUERY: begin
          beat_nxt.cnt = fired_r;
        end
        default: begin
        end
      endcase
    end else if (claim) begin
      // first free entry takes a new rule
      point_nxt         = beat_i.point;
      mode_nxt          = beat_i.mode;
      period_nxt        = (beat_i.mode == fir_pkg::MODE_EVERY_N) ? beat_i.every_n : 32'd0;
      seen_nxt          = 32'd0;
      phase_nxt         = 32'd0;
      fired_nxt         = 32'd0;
      enabled_nxt       = 1'b1;
      beat_nxt.appended = 1'b1;
      beat_nxt.cnt      = 32'd0;
    end
  end

  // beat register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  // rule storage
  always_ff @(posedge clk) begin
    point_r   <= point_nxt;
    mode_r    <= mode_nxt;
    period_r  <= period_nxt;
    seen_r    <= seen_nxt;
    phase_r   <= phase_nxt;
    fired_r   <= fired_nxt;
    enabled_r <= enabled_nxt;
  end

  assign beat_o = beat_r;

endmodule

/* design/fault_injection_rule_table.sv */
// An accepted request beat walks the cell chain through the beat register of each rule cell,
// is captured in the result register, then waits for out_bus.ready to load the output register.
// A new request is taken only once the last one has left the chain and its result is loaded.
// The output register frees the input side: a new request is taken while a result waits.
// Reset (synchronous, rst_n low): the table is empty and no beat is in flight.
module fault_injection_rule_table (
  input logic        clk,
  input logic        rst_n,
  fir_in_if.sink     in_bus,
  fir_out_if.source  out_bus
);

  fir_pkg::state_t              state_r, state_nxt;
  logic [fir_pkg::CNT_W-1:0]    rules_in_use_r, rules_in_use_nxt;
  fir_pkg::result_t             res_r, res_nxt;
  fir_pkg::result_t             out_res_r;
  logic                         out_valid_r, out_valid_nxt;

  fir_pkg::beat_t               beat_w [0:fir_pkg::MAX_RULES];
  fir_pkg::beat_t               beat_in;
  fir_pkg::beat_t               end_beat;
  logic [fir_pkg::MAX_RULES-1:0] vld_vec;

  logic in_fire;
  logic out_free;
  logic cfg_ok;
  logic cap_res;
  logic load_out;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // configure request checks that need no table lookup
  assign cfg_ok = ({1'b0, in_bus.point} < 5'(fir_pkg::NUM_POINTS)) &&
                  (in_bus.mode != fir_pkg::MODE_INVALID) &&
                  !((in_bus.mode == fir_pkg::MODE_EVERY_N) && (in_bus.every_n == 32'd0));

  // beat entering the chain
  always_comb begin
    beat_in          = '0;
    beat_in.vld      = in_fire;
    beat_in.req      = in_bus.req_type;
    beat_in.point    = in_bus.point;
    beat_in.mode     = in_bus.mode;
    beat_in.every_n  = in_bus.every_n;
    beat_in.ok       = cfg_ok;
  end

  assign beat_w[0] = beat_in;

  // chain of rule cells
  for (genvar i = 0; i < fir_pkg::MAX_RULES; i++) begin : g_cell
    fir_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx_i   (fir_pkg::IDX_W'(i)),
      .count_i (rules_in_use_r),
      .beat_i  (beat_w[i]),
      .beat_o  (beat_w[i+1])
    );
    assign vld_vec[i] = beat_w[i+1].vld;
  end

  assign end_beat = beat_w[fir_pkg::MAX_RULES];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fir_pkg::ST_IDLE:  if (in_fire) state_nxt = fir_pkg::ST_RUN;
      fir_pkg::ST_RUN:   if (end_beat.vld) state_nxt = fir_pkg::ST_DRAIN;
      fir_pkg::ST_DRAIN: if (out_free) state_nxt = fir_pkg::ST_IDLE;
      default:           state_nxt = fir_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_bus.ready = 1'b0;
    cap_res      = 1'b0;
    load_out     = 1'b0;
    unique case (state_r)
      fir_pkg::ST_IDLE:  in_bus.ready = 1'b1;
      fir_pkg::ST_RUN:   cap_res = end_beat.vld;
      fir_pkg::ST_DRAIN: load_out = out_free;
      default: begin
      end
    endcase
  end

  // result and rule count from the beat leaving the chain
  always_comb begin
    res_nxt          = res_r;
    rules_in_use_nxt = rules_in_use_r;
    if (cap_res) begin
      res_nxt.fire        = end_beat.fire;
      res_nxt.fired_count = end_beat.cnt;
      priority if (end_beat.req == fir_pkg::REQ_CLEAR) begin
        res_nxt.accepted = 1'b1;
        rules_in_use_nxt = '0;
      end else if (end_beat.req == fir_pkg::REQ_CONFIGURE) begin
        res_nxt.accepted = end_beat.ok && (end_beat.matched || end_beat.appended);
        if (end_beat.appended) begin
          rules_in_use_nxt = rules_in_use_r + fir_pkg::CNT_W'(1);
        end
      end else begin
        res_nxt.accepted = 1'b0;
      end
    end
  end

  // output register
  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= fir_pkg::ST_IDLE;
      rules_in_use_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rules_in_use_r <= rules_in_use_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (load_out) begin
      out_res_r <= res_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.accepted    = out_res_r.accepted;
  assign out_bus.fire        = out_res_r.fire;
  assign out_bus.fired_count = out_res_r.fired_count;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    rules_in_use_r <= fir_pkg::CNT_W'(fir_pkg::MAX_RULES))
    else $error("rule count beyond table size");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= 1)
    else $error("more than one beat in the cell chain");

  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == fir_pkg::ST_RUN)
    else $error("accepted request did not start the chain walk");

  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    end_beat.vld |-> state_r == fir_pkg::ST_RUN)
    else $error("beat left the chain outside the walk");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// rule table predictor plus the queue of outcomes still owed by the block
class rule_table_scoreboard;
  int unsigned       rules_held;
  logic [3:0]        slot_point [fir_pkg::MAX_RULES];
  logic [1:0]        slot_mode [fir_pkg::MAX_RULES];
  logic [31:0]       slot_period [fir_pkg::MAX_RULES];
  logic [31:0]       slot_seen [fir_pkg::MAX_RULES];
  logic [31:0]       slot_fired [fir_pkg::MAX_RULES];
  bit                slot_on [fir_pkg::MAX_RULES];
  fir_pkg::result_t  pending_outcomes [$];
  int unsigned       mismatches;

  function new();
    rules_held = 0;
    mismatches = 0;
    for (int i = 0; i < fir_pkg::MAX_RULES; i++) begin
      slot_point[i]  = '0;
      slot_mode[i]   = '0;
      slot_period[i] = '0;
      slot_seen[i]   = '0;
      slot_fired[i]  = '0;
      slot_on[i]     = 1'b0;
    end
  endfunction

  // linear search over the rules held, -1 when the point has none
  function int find_slot(logic [3:0] p);
    for (int i = 0; i < rules_held; i++) begin
      if (slot_point[i] == p) return i;
    end
    return -1;
  endfunction

  function int pending_count();
    return pending_outcomes.size();
  endfunction

  // apply one accepted request beat and queue the outcome it must produce
  function void record_request(logic [2:0] req, logic [3:0] p, logic [1:0] m,
                               logic [31:0] n);
    fir_pkg::result_t want;
    int               k;
    logic             ok;
    want = '0;
    k = find_slot(p);
    case (req)
      fir_pkg::REQ_CHECK: begin
        if (k >= 0 && slot_on[k]) begin
          slot_seen[k] = slot_seen[k] + 32'd1;
          case (slot_mode[k])
            fir_pkg::MODE_ONCE: want.fire = (slot_fired[k] == 32'd0);
            fir_pkg::MODE_EVERY_N: begin
              if (slot_period[k] != 32'd0)
                want.fire = ((slot_seen[k] % slot_period[k]) == 32'd0);
            end
            fir_pkg::MODE_ALWAYS: want.fire = 1'b1;
            default: want.fire = 1'b0;
          endcase
          if (want.fire) slot_fired[k] = slot_fired[k] + 32'd1;
        end
        if (k >= 0) want.fired_count = slot_fired[k];
      end
      fir_pkg::REQ_CONFIGURE: begin
        ok = (p < fir_pkg::NUM_POINTS) && (m <= fir_pkg::MODE_ALWAYS) &&
             !(m == fir_pkg::MODE_EVERY_N && n == 32'd0);
        // a new point takes the next free slot unless the table is full
        if (ok && k < 0) begin
          if (rules_held >= fir_pkg::MAX_RULES) begin
            ok = 1'b0;
          end else begin
            k = rules_held;
            rules_held++;
          end
        end
        if (ok) begin
          slot_point[k]  = p;
          slot_mode[k]   = m;
          slot_period[k] = (m == fir_pkg::MODE_EVERY_N) ? n : 32'd0;
          slot_seen[k]   = 32'd0;
          slot_fired[k]  = 32'd0;
          slot_on[k]     = 1'b1;
          want.accepted  = 1'b1;
        end
        if (k >= 0) want.fired_count = slot_fired[k];
      end
      fir_pkg::REQ_DISABLE: begin
        if (k >= 0) begin
          slot_on[k] = 1'b0;
          want.fired_count = slot_fired[k];
        end
      end
      fir_pkg::REQ_QUERY: begin
        if (k >= 0) want.fired_count = slot_fired[k];
      end
      fir_pkg::REQ_CLEAR: begin
        rules_held = 0;
        want.accepted = 1'b1;
      end
      default: ;
    endcase
    pending_outcomes.push_back(want);
  endfunction

  // compare one result beat against the oldest outcome owed
  function void compare_outcome(logic acc, logic fire, logic [31:0] cnt);
    fir_pkg::result_t want;
    if (pending_outcomes.size() == 0) begin
      $error("result beat with no request waiting: accepted %0b fire %0b fired_count %0d",
             acc, fire, cnt);
      mismatches++;
      return;
    end
    want = pending_outcomes.pop_front();
    if (acc !== want.accepted) begin
      $error("accepted mismatch: expected %0b, actual %0b", want.accepted, acc);
      mismatches++;
    end
    if (fire !== want.fire) begin
      $error("fire mismatch: expected %0b, actual %0b", want.fire, fire);
      mismatches++;
    end
    if (cnt !== want.fired_count) begin
      $error("fired_count mismatch: expected %0d, actual %0d", want.fired_count, cnt);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam int LATENCY     = fir_pkg::MAX_RULES + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 475;

  logic clk;
  logic rst_n;

  fir_in_if  in_bus ();
  fir_out_if out_bus ();

  fault_injection_rule_table u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  rule_table_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // watch both channels; results first, they belong to older requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready)
        sb.compare_outcome(out_bus.accepted, out_bus.fire, out_bus.fired_count);
      if (in_bus.valid && in_bus.ready)
        sb.record_request(in_bus.req_type, in_bus.point, in_bus.mode, in_bus.every_n);
    end
  end

  // drive one request beat and hold it until it is taken
  task automatic send_request(logic [2:0] req, logic [3:0] p, logic [1:0] m,
                              logic [31:0] n);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= req;
    in_bus.point    <= p;
    in_bus.mode     <= m;
    in_bus.every_n  <= n;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // hold the sender off until every owed result has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // mostly well-formed traffic on valid points, some noise
  task automatic random_request(output bit counted);
    int unsigned sel;
    int unsigned pick;
    logic [2:0]  req;
    logic [3:0]  p;
    logic [1:0]  m;
    logic [31:0] n;
    sel = $urandom_range(0, 99);
    p = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(fir_pkg::NUM_POINTS, 15))
                                     : 4'($urandom_range(0, fir_pkg::NUM_POINTS - 1));
    m = 2'($urandom_range(0, 3));
    n = $urandom;
    if (sel < 45) begin
      req = fir_pkg::REQ_CHECK;
    end else if (sel < 65) begin
      req = fir_pkg::REQ_CONFIGURE;
      m = ($urandom_range(0, 9) == 0) ? fir_pkg::MODE_INVALID : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      if (pick < 7) n = 32'($urandom_range(1, 6));
      else if (pick == 7) n = 32'd0;
    end else if (sel < 73) begin
      req = fir_pkg::REQ_DISABLE;
    end else if (sel < 85) begin
      req = fir_pkg::REQ_QUERY;
    end else if (sel < 88) begin
      req = fir_pkg::REQ_CLEAR;
    end else if (sel < 92) begin
      req = 3'($urandom_range(5, 7));
    end else begin
      req = 3'($urandom_range(0, 7));
      p = 4'($urandom_range(0, 15));
    end
    counted = (req <= fir_pkg::REQ_CLEAR);
    send_request(req, p, m, n);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned sink_pct);
    int unsigned done;
    bit          counted;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      random_request(counted);
      if (counted) done++;
    end
  endtask

  // main sequence
  initial begin
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= '0;
    in_bus.point    <= '0;
    in_bus.mode     <= '0;
    in_bus.every_n  <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unmatched points on an empty table
    send_request(fir_pkg::REQ_CLEAR, 4'd0, fir_pkg::MODE_ONCE, 32'd0);
    send_request(fir_pkg::REQ_QUERY, 4'd3, fir_pkg::MODE_ONCE, 32'd0);
    send_request(fir_pkg::REQ_CHECK, 4'd3, fir_pkg::MODE_ONCE, 32'd0);
    send_request(fir_pkg::REQ_DISABLE, 4'd3, fir_pkg::MODE_ONCE, 32'd0);
    // fire once
    send_request(fir_pkg::REQ_CONFIGURE, 4'd0, fir_pkg::MODE_ONCE, 32'hFFFF_FFFF);
    send_request(fir_pkg::REQ_CHECK, 4'd0, fir_pkg::MODE_ONCE, 32'd0);
    send_request(fir_pkg::REQ_CHECK, 4'd0, fir_pkg::MODE_ONCE, 32'd0);
    send_request(fir_pkg::REQ_QUERY, 4'd0, fir_pkg::MODE_ONCE, 32'd0);
    // every third occurrence
    send_request(fir_pkg::REQ_CONFIGURE, 4'd1, fir_pkg::MODE_EVERY_N, 32'd3);
    repeat (3) send_request(fir_pkg::REQ_CHECK, 4'd1, fir_pkg::MODE_ONCE, 32'd0);
    // always, with a period that must not be stored
    send_request(fir_pkg::REQ_CONFIGURE, 4'd9, fir_pkg::MODE_ALWAYS, 32'hFFFF_FFFF);
    send_request(fir_pkg::REQ_CHECK, 4'd9, fir_pkg::MODE_ONCE, 32'd0);
    // rejected configures: zero period, bad points, bad mode
    send_request(fir_pkg::REQ_CONFIGURE, 4'd4, fir_pkg::MODE_EVERY_N, 32'd0);
    send_request(fir_pkg::REQ_CONFIGURE, 4'd15, fir_pkg::MODE_ALWAYS, 32'd1);
    send_request(fir_pkg::REQ_CONFIGURE, 4'd10, fir_pkg::MODE_ONCE, 32'd1);
    send_request(fir_pkg::REQ_CONFIGURE, 4'd1, fir_pkg::MODE_INVALID, 32'd2);
    // replace a rule with the widest period
    send_request(fir_pkg::REQ_CONFIGURE, 4'd0, fir_pkg::MODE_EVERY_N, 32'hFFFF_FFFF);
    send_request(fir_pkg::REQ_CHECK, 4'd0, fir_pkg::MODE_ONCE, 32'd0);
    // disabled rule neither counts nor fires
    send_request(fir_pkg::REQ_DISABLE, 4'd9, fir_pkg::MODE_ONCE, 32'd0);
    send_request(fir_pkg::REQ_CHECK, 4'd9, fir_pkg::MODE_ONCE, 32'd0);
    // unused request codes
    send_request(3'd5, 4'd1, fir_pkg::MODE_INVALID, 32'hFFFF_FFFF);
    send_request(3'd7, 4'd15, fir_pkg::MODE_EVERY_N, 32'hA5A5_5A5A);
    // after a clear nothing matches
    send_request(fir_pkg::REQ_CLEAR, 4'd15, fir_pkg::MODE_INVALID, 32'hFFFF_FFFF);
    send_request(fir_pkg::REQ_CHECK, 4'd1, fir_pkg::MODE_ONCE, 32'd0);
    wait_drained();

    // random phases with different idling
    run_phase(0, 0);
    run_phase(54, 0);
    run_phase(0, 54);
    wait_drained();
    run_phase(6, 6);
    in_bus.valid <= 1'b0;

    // drain and give stray beats a chance to show up
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
